@@ rtl/acsc_pkg.sv @@
// ----------------------------------------------------------------------------
// acsc_pkg: shared types, constants and tables of the ARX counter cipher
// Word type, sequencer codes, quad unit command and the rotation and
// word-group tables used by the round sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acsc_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [3:0] word4_t;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned NumWords   = 16;

  // request action codes
  localparam logic ActRekey = 1'b0;
  localparam logic ActData  = 1'b1;

  // special word groups
  localparam logic [3:0] GrpKeyRow = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_LOADQ,
    ST_RUN,
    ST_ANTI,
    ST_STOREQ,
    ST_SAVE,
    ST_LOADB,
    ST_CTR,
    ST_ADDB,
    ST_ADDK,
    ST_BYTE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_DERIVE,
    PH_B0,
    PH_BDIAG,
    PH_BMIX
  } phase_e;

  typedef enum logic [2:0] {
    Q_NOP,
    Q_LOAD,
    Q_HALF0,
    Q_HALF1,
    Q_ANTI_LO,
    Q_ANTI_HI
  } qop_e;

  typedef struct packed {
    qop_e       op;
    logic [1:0] slot;
    logic [5:0] rot;
    word_t      data;
  } qcmd_t;

  function automatic word_t key_const(logic [1:0] i);
    word_t k;
    case (i)
      2'd0:    k = 64'hbd5bc326d7b42f7b;
      2'd1:    k = 64'h7a73cb2b5b7c27c0;
      2'd2:    k = 64'h4d6af9625ec1db68;
      default: k = 64'h6828f43bfe0143bb;
    endcase
    return k;
  endfunction

  function automatic word_t rotl(word_t x, logic [5:0] r);
    return (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  // rotation of the confuse rounds: round r, half h
  function automatic logic [5:0] conf_rot(logic [2:0] r, logic h);
    logic [11:0] p;
    case (r)
      3'd0:    p = {6'd28, 6'd31};
      3'd1:    p = {6'd22, 6'd25};
      3'd2:    p = {6'd16, 6'd19};
      3'd3:    p = {6'd11, 6'd13};
      3'd4:    p = {6'd5,  6'd8};
      default: p = {6'd3,  6'd4};
    endcase
    return h ? p[11:6] : p[5:0];
  endfunction

  // rotation of the mix rounds
  function automatic logic [5:0] mix_rot(logic [1:0] r, logic h);
    logic [11:0] p;
    case (r)
      2'd0:    p = {6'd23, 6'd31};
      2'd1:    p = {6'd7,  6'd15};
      default: p = {6'd3,  6'd5};
    endcase
    return h ? p[11:6] : p[5:0];
  endfunction

  // word index of slot s in group g: columns 0-3, diagonals 4-11, key row 12
  function automatic logic [3:0] grp_word(logic [3:0] g, logic [1:0] s);
    logic [15:0] d;
    logic [3:0]  w;
    case (g)
      4'd4:    d = 16'hFA50;
      4'd5:    d = 16'hC963;
      4'd6:    d = 16'hE871;
      4'd7:    d = 16'hDB42;
      4'd8:    d = 16'hDA70;
      4'd9:    d = 16'hE943;
      4'd10:   d = 16'hCB61;
      4'd11:   d = 16'hF852;
      default: d = 16'h0000;
    endcase
    if (g < 4'd4) begin
      w = {s, g[1:0]};
    end else if (g == GrpKeyRow) begin
      w = {2'b10, s};
    end else begin
      w = d[{s, 2'b00} +: 4];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/acsc_in_if.sv @@
// ----------------------------------------------------------------------------
// acsc_in_if: request channel of the cipher
// Valid/ready handshake carrying action, data bytes and byte count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acsc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] data_in;
  logic [3:0]  byte_count;

  modport source (output valid, action, data_in, byte_count, input ready);
  modport sink   (input valid, action, data_in, byte_count, output ready);
endinterface

`default_nettype wire

@@ rtl/acsc_out_if.sv @@
// ----------------------------------------------------------------------------
// acsc_out_if: result channel of the cipher
// Valid/ready handshake carrying processed bytes and the overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acsc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic        counter_overflow;

  modport source (output valid, data_out, counter_overflow, input ready);
  modport sink   (input valid, data_out, counter_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/arx_counter_stream_cipher.sv @@
// A rekey derives the base and anti key states; a data request processes up to
// eight bytes and makes a new 128-byte keystream block, with MIX_PASSES mix
// passes, whenever the current one is used up. One request at a time; the one
// quad unit and the single port on the working state are shared by all steps.
// Reset: asynchronous, active low; keys, derived key states and counter clear, block used up.
`timescale 1ns / 1ps
`default_nettype none

module arx_counter_stream_cipher #(
  parameter int unsigned MIX_PASSES = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  acsc_in_if.sink          in_i,
  acsc_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import acsc_pkg::*;

  localparam int unsigned PassW = (MIX_PASSES > 1) ? $clog2(MIX_PASSES) : 1;

  // control state
  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [3:0]         step_q, step_d;
  logic [PassW-1:0]   pass_q, pass_d;
  logic               inv_q, inv_d;
  logic [3:0]         idx_q, idx_d;
  logic [3:0]         rnd_q, rnd_d;
  logic [7:0]         bpos_q, bpos_d;
  word_t              bc_q, bc_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [3:0]         x_q, x_d;
  logic               wrap_q, wrap_d;
  logic               out_valid_q, out_valid_d;

  // payload
  word_t              data_q, data_d;
  word_t              res_q, res_d;
  word_t              out_data_q, out_data_d;
  logic               out_ovf_q, out_ovf_d;

  // state stores
  word_t              w_q [NumWords];
  word_t              base_q [NumWords];
  word_t              aks_q [NumWords];
  word_t              ks_q [NumWords];

  word4_t             key, nonce;
  word4_t             quad;
  qcmd_t              qcmd;
  logic [3:0]         gsel, w_raddr, w_waddr, b_raddr;
  logic               w_we, base_we, aks_we, ks_we;
  word_t              w_rd, w_wdata, init_word, sum12;
  logic [3:0]         last_rnd;
  logic [7:0]         kbyte, dbyte;
  logic               in_take;

  acsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .key_o   (key),
    .nonce_o (nonce)
  );

  acsc_quad_unit u_quad (
    .clk_i  (clk_i),
    .cmd_i  (qcmd),
    .quad_o (quad)
  );

  assign pready     = 1'b1;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take    = in_i.valid & (state_q == ST_IDLE);

  // current word group from phase and step
  always_comb begin
    case (phase_q)
      PH_DERIVE: begin
        if (step_q == 4'd0) begin
          gsel = GrpKeyRow;
        end else if (step_q <= 4'd4) begin
          gsel = step_q - 4'd1;
        end else begin
          gsel = step_q - 4'd5;
        end
      end
      PH_B0:    gsel = 4'd0;
      PH_BDIAG: gsel = step_q + 4'd4;
      PH_BMIX:  gsel = step_q;
      default:  gsel = 4'd0;
    endcase
  end

  // working state read port
  always_comb begin
    case (state_q)
      ST_LOADQ: w_raddr = grp_word(gsel, idx_q[1:0]);
      ST_ADDB:  w_raddr = {idx_q[1:0], 2'b00};
      ST_CTR:   w_raddr = 4'd12;
      default:  w_raddr = idx_q;
    endcase
    b_raddr = (state_q == ST_LOADB) ? idx_q : {idx_q[1:0], 2'b00};
  end

  assign w_rd  = w_q[w_raddr];
  assign sum12 = w_rd + bc_q;

  // initial derive words: constants, key twice, nonce
  always_comb begin
    if (idx_q < 4'd4) begin
      init_word = key_const(idx_q[1:0]);
    end else if (idx_q < 4'd12) begin
      init_word = key[idx_q[1:0]] ^ {64{inv_q}};
    end else begin
      init_word = nonce[idx_q[1:0]] ^ {64{inv_q}};
    end
  end

  // working state write port
  always_comb begin
    w_we    = 1'b0;
    w_waddr = idx_q;
    w_wdata = init_word;
    case (state_q)
      ST_INIT: w_we = 1'b1;
      ST_STOREQ: begin
        w_we    = 1'b1;
        w_waddr = grp_word(gsel, idx_q[1:0]);
        w_wdata = quad[idx_q[1:0]];
      end
      ST_LOADB: begin
        w_we    = 1'b1;
        w_wdata = base_q[b_raddr];
      end
      ST_CTR: begin
        w_we    = 1'b1;
        w_waddr = 4'd12;
        w_wdata = sum12;
      end
      ST_ADDB: begin
        w_we    = 1'b1;
        w_waddr = {idx_q[1:0], 2'b00};
        w_wdata = w_rd + base_q[b_raddr];
      end
      default: ;
    endcase
  end

  assign base_we = (state_q == ST_SAVE) && !inv_q;
  assign aks_we  = (state_q == ST_SAVE) && inv_q;
  assign ks_we   = (state_q == ST_ADDK);

  // quad unit command
  assign last_rnd = (phase_q == PH_BMIX) ? 4'd5 : 4'd11;

  always_comb begin
    qcmd.op   = Q_NOP;
    qcmd.slot = idx_q[1:0];
    qcmd.data = w_rd;
    qcmd.rot  = (phase_q == PH_BMIX) ? mix_rot(rnd_q[2:1], rnd_q[0])
                                     : conf_rot(rnd_q[3:1], rnd_q[0]);
    case (state_q)
      ST_LOADQ: qcmd.op = Q_LOAD;
      ST_RUN:   qcmd.op = rnd_q[0] ? Q_HALF1 : Q_HALF0;
      ST_ANTI:  qcmd.op = idx_q[0] ? Q_ANTI_HI : Q_ANTI_LO;
      default:  ;
    endcase
  end

  // keystream and data byte at the current position
  always_comb begin
    kbyte = ks_q[bpos_q[6:3]][{bpos_q[2:0], 3'b000} +: 8];
    dbyte = data_q[{x_q[2:0], 3'b000} +: 8];
  end

  // sequencer: next state and control
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    pass_d      = pass_q;
    inv_d       = inv_q;
    idx_d       = idx_q;
    rnd_d       = rnd_q;
    bpos_d      = bpos_q;
    bc_d        = bc_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    wrap_d      = wrap_q;
    data_d      = data_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q & ~out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          res_d  = '0;
          wrap_d = 1'b0;
          idx_d  = '0;
          x_d    = '0;
          data_d = in_i.data_in;
          cnt_d  = (in_i.byte_count > 4'd8) ? 4'd8 : in_i.byte_count;
          if (in_i.action == ActRekey) begin
            state_d = ST_INIT;
            phase_d = PH_DERIVE;
            step_d  = '0;
            inv_d   = 1'b0;
            bc_d    = '0;
            bpos_d  = 8'(BlockBytes);
          end else begin
            state_d = ST_BYTE;
          end
        end
      end

      ST_INIT: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          state_d = ST_LOADQ;
        end
      end

      ST_LOADQ: begin
        idx_d = idx_q + 4'd1;
        rnd_d = '0;
        if (idx_q == 4'd3) begin
          idx_d   = '0;
          state_d = (phase_q == PH_DERIVE && step_q >= 4'd5) ? ST_ANTI : ST_RUN;
        end
      end

      ST_RUN: begin
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == last_rnd) begin
          state_d = ST_STOREQ;
        end
      end

      ST_ANTI: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd1) begin
          idx_d   = '0;
          state_d = ST_STOREQ;
        end
      end

      // group written back: choose the next group, or save, add or end the sweep
      ST_STOREQ: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd3) begin
          idx_d   = '0;
          state_d = ST_LOADQ;
          step_d  = step_q + 4'd1;
          case (phase_q)
            PH_DERIVE: begin
              if (step_q == 4'd8) begin
                state_d = ST_SAVE;
              end
            end
            PH_B0: state_d = ST_ADDB;
            PH_BDIAG: begin
              if (step_q == 4'd7) begin
                phase_d = PH_BMIX;
                step_d  = '0;
                pass_d  = '0;
              end
            end
            PH_BMIX: begin
              if (step_q == 4'd11) begin
                step_d = '0;
                pass_d = pass_q + PassW'(1);
                if (pass_q == PassW'(MIX_PASSES - 1)) begin
                  state_d = ST_ADDK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SAVE: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          if (inv_q) begin
            state_d = ST_DONE;
          end else begin
            inv_d   = 1'b1;
            step_d  = '0;
            state_d = ST_INIT;
          end
        end
      end

      ST_LOADB: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          state_d = ST_CTR;
        end
      end

      ST_CTR: begin
        if ((bc_q != '0) && (sum12 < w_rd)) begin
          wrap_d = 1'b1;
        end
        phase_d = PH_B0;
        step_d  = '0;
        idx_d   = '0;
        state_d = ST_LOADQ;
      end

      ST_ADDB: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd3) begin
          idx_d   = '0;
          phase_d = PH_BDIAG;
          step_d  = '0;
          state_d = ST_LOADQ;
        end
      end

      ST_ADDK: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          bc_d    = bc_q + 64'd1;
          bpos_d  = '0;
          state_d = ST_BYTE;
        end
      end

      // one byte a cycle; make a block when the current one is used up
      ST_BYTE: begin
        if (x_q == cnt_q) begin
          state_d = ST_DONE;
        end else if (bpos_q[7]) begin
          idx_d   = '0;
          state_d = ST_LOADB;
        end else begin
          res_d[{x_q[2:0], 3'b000} +: 8] = dbyte ^ kbyte;
          x_d    = x_q + 4'd1;
          bpos_d = bpos_q + 8'd1;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          out_ovf_d   = wrap_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DERIVE;
      step_q      <= '0;
      pass_q      <= '0;
      inv_q       <= 1'b0;
      idx_q       <= '0;
      rnd_q       <= '0;
      bpos_q      <= 8'(BlockBytes);
      bc_q        <= '0;
      cnt_q       <= '0;
      x_q         <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      inv_q       <= inv_d;
      idx_q       <= idx_d;
      rnd_q       <= rnd_d;
      bpos_q      <= bpos_d;
      bc_q        <= bc_d;
      cnt_q       <= cnt_d;
      x_q         <= x_d;
      wrap_q      <= wrap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers and working stores
  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
    out_ovf_q  <= out_ovf_d;
    if (w_we) begin
      w_q[w_waddr] <= w_wdata;
    end
    if (ks_we) begin
      ks_q[idx_q] <= w_rd + aks_q[idx_q];
    end
  end

  // derived key states, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        base_q[i] <= '0;
        aks_q[i]  <= '0;
      end
    end else begin
      if (base_we) begin
        base_q[idx_q] <= w_rd;
      end
      if (aks_we) begin
        aks_q[idx_q] <= w_rd;
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.data_out         = out_data_q;
  assign out_o.counter_overflow = out_ovf_q;

  // byte position never passes the end of a block
  a_bpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bpos_q <= 8'(BlockBytes))
    else $error("byte position beyond block");

  // a rekey request starts the derive sweep
  a_rekey_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_i.action == ActRekey) |=> (state_q == ST_INIT))
    else $error("rekey did not start derive");

  // round counter stays within the rounds of the current kind
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rnd_q <= last_rnd))
    else $error("round counter overrun");

  // block counter moves only after a block or on rekey
  a_bc_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bc_q != $past(bc_q)) |-> ($past(state_q) == ST_ADDK || $past(state_q) == ST_IDLE))
    else $error("block counter changed unexpectedly");

endmodule

`default_nettype wire

@@ rtl/acsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// acsc_cfg_regs: key and nonce register bank
// APB-style write/read of the eight 64-bit key and nonce words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acsc_cfg_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [5:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic [63:0]         prdata,
  output acsc_pkg::word4_t    key_o,
  output acsc_pkg::word4_t    nonce_o
);
  import acsc_pkg::*;

  word_t regs_q [8];
  logic  wr_en;

  assign wr_en = psel & penable & pwrite;

  // register writes, word index from the address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else if (wr_en) begin
      regs_q[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = regs_q[paddr[5:3]];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_o[i]   = regs_q[i];
      nonce_o[i] = regs_q[i + 4];
    end
  end

endmodule

`default_nettype wire

@@ rtl/acsc_quad_unit.sv @@
// ----------------------------------------------------------------------------
// acsc_quad_unit: shared ARX unit over a four-word working quad
// Loads four words, then applies one half round or one anti-inverse half
// per cycle under command of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acsc_quad_unit (
  input  wire logic            clk_i,
  input  wire acsc_pkg::qcmd_t cmd_i,
  output acsc_pkg::word4_t     quad_o
);
  import acsc_pkg::*;

  word4_t       q_q, q_d;
  logic         carry_q, carry_d;
  word_t        h0, h1;
  logic [64:0]  tl;
  word_t        th;

  always_comb begin
    h0 = rotl(q_q[0] ^ q_q[1], cmd_i.rot);
    h1 = rotl(q_q[2] ^ q_q[3], cmd_i.rot);
    tl = {1'b0, q_q[0]} + {1'b0, q_q[2]};
    th = q_q[1] + q_q[3] + {63'd0, carry_q};
    q_d     = q_q;
    carry_d = carry_q;
    case (cmd_i.op)
      Q_LOAD:    q_d[cmd_i.slot] = cmd_i.data;
      // a ^= b, rotate, d += a
      Q_HALF0: begin
        q_d[0] = h0;
        q_d[3] = q_q[3] + h0;
      end
      // c ^= d, rotate, b += c
      Q_HALF1: begin
        q_d[2] = h1;
        q_d[1] = q_q[1] + h1;
      end
      Q_ANTI_LO: begin
        q_d[0]  = q_q[0] ^ tl[63:0];
        q_d[2]  = q_q[2] ^ ~tl[63:0];
        carry_d = tl[64];
      end
      Q_ANTI_HI: begin
        q_d[1] = q_q[1] ^ th;
        q_d[3] = q_q[3] ^ ~th;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q     <= q_d;
    carry_q <= carry_d;
  end

  assign quad_o = q_q;

endmodule

`default_nettype wire
